// ===== rtl/core/lpc_pkg.sv =====
`default_nettype none
package lpc_pkg;

    // register indexes on the configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_VSTEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXR  = 2'd1;

    localparam logic [15:0] VSTEP_RST = 16'd0;
    localparam logic [23:0] MAXR_RST  = 24'd70656;

    // 1.0 in Q30
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    // fractional part of pi/2 in Q32 (integer part is 1)
    localparam logic [31:0] HALF_PI_FRAC = 32'd2451551556;

    // ceil(2^29 / 45): exact floor division by 45 for values below 2^23
    localparam logic [23:0] M45 = 24'd11930465;

    // register stages through lpc_sincos
    localparam int SC_LAT = 24;

    typedef logic [44:0][16:0] t_tab45;

    // floor((b * 2^17 + 22) / 45): low phase bits for a remainder b of 45
    function automatic t_tab45 f_tab45();
        t_tab45 t;
        for (int b = 0; b < 45; b++) begin
            t[b] = 17'(((64'(b) << 17) + 64'd22) / 64'd45);
        end
        return t;
    endfunction

    localparam t_tab45 TAB45 = f_tab45();

    typedef struct packed {
        logic        s_neg;
        logic [16:0] s_mag;
        logic        c_neg;
        logic [16:0] c_mag;
    } t_trig;

endpackage
`default_nettype wire

// ===== rtl/core/lidar_polar_to_cartesian.sv =====
// Lidar return to cartesian point converter.
// Throughput: one item per cycle; the pipeline advances unless the output
// register holds a result that is stalled.
// Reset (synchronous, active low) empties the pipeline and restores the
// configuration registers; there is no memory to clear.
`default_nettype none
module lidar_polar_to_cartesian #(
    parameter int YAW_STEPS    = 1800,
    parameter int PLANES       = 32,
    parameter int PLANE_OFFSET = 23
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [10:0]                   i_yaw_step,
    input  wire logic [4:0]                    i_plane,
    input  wire logic [23:0]                   i_range,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic signed [24:0]                 o_pos_x,
    output logic signed [24:0]                 o_pos_y,
    output logic signed [24:0]                 o_pos_z,
    input  wire logic                          i_cfg_we,
    input  wire logic [lpc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [23:0]                   i_cfg_data
);
    import lpc_pkg::*;

    // yaw phase = step * Q + floor((step * RM + Y/2) / Y), with 2^32 = Q*Y + RM
    localparam logic [30:0] YAW_Q  = 31'(64'h1_0000_0000 / YAW_STEPS);
    localparam logic [15:0] YAW_RM = 16'(64'h1_0000_0000 % YAW_STEPS);
    localparam logic [16:0] YAW_N  = 17'(YAW_STEPS);
    localparam logic [15:0] YAW_H  = 16'(YAW_STEPS / 2);
    localparam int NV = 7 + SC_LAT + 3;
    localparam int NR = 7 + SC_LAT + 1;

    logic        w_en;
    logic        w_acc;
    logic        w_keep;

    logic [15:0] r_vstep;
    logic [23:0] r_maxr;
    logic        r_vld [NV];
    logic        r_out_vld;
    logic [23:0] r_rng [NR];

    // phase stages
    logic [10:0]        r0_step;
    logic signed [24:0] r0_d;
    logic [26:0]        r1_sm;
    logic [31:0]        r1_sq;
    logic [22:0]        r1_m;
    logic               r1_neg;
    logic [27:0]        r2_n;
    logic [31:0]        r2_sq;
    logic [17:0]        r2_a;
    logic [22:0]        r2_m;
    logic               r2_neg;
    logic [11:0]        r3_qe;
    logic [27:0]        r3_n;
    logic [31:0]        r3_sq;
    logic [17:0]        r3_a;
    logic [5:0]         r3_b;
    logic               r3_neg;
    logic [28:0]        r4_pr;
    logic [11:0]        r4_qe;
    logic [27:0]        r4_n;
    logic [31:0]        r4_sq;
    logic [31:0]        r4_p;
    logic               r4_neg;
    logic [11:0]        r5_q2;
    logic [31:0]        r5_sq;
    logic [31:0]        r5_pph;
    logic [31:0]        r6_yph;
    logic [31:0]        r6_pph;

    // output stages
    logic [32:0] r_o1_cc;
    logic [32:0] r_o1_sc;
    logic [40:0] r_o1_zz;
    logic        r_o1_xn;
    logic        r_o1_yn;
    logic        r_o1_zn;
    logic [56:0] r_o2_px;
    logic [56:0] r_o2_py;
    logic [23:0] r_o2_z;
    logic        r_o2_xn;
    logic        r_o2_yn;
    logic        r_o2_zn;
    logic [23:0] r_o3_x;
    logic [23:0] r_o3_y;
    logic [23:0] r_o3_z;
    logic        r_o3_xn;
    logic        r_o3_yn;
    logic        r_o3_zn;
    logic signed [24:0] r_pos_x;
    logic signed [24:0] r_pos_y;
    logic signed [24:0] r_pos_z;

    logic signed [7:0]  w_diff;
    logic signed [24:0] n_d;
    logic [24:0]        w_dabs;
    logic [26:0]        w_sm;
    logic [41:0]        w_sq;
    logic [46:0]        w_pa;
    logic [58:0]        w_nq;
    logic [23:0]        w_a45;
    logic [23:0]        w_b;
    logic [28:0]        w_pr;
    logic [28:0]        w_rem;
    logic [31:0]        w_p;
    t_trig              w_ty;
    t_trig              w_tp;
    logic [33:0]        w_cc;
    logic [33:0]        w_sc;
    logic [40:0]        w_zz;
    logic [56:0]        w_px;
    logic [56:0]        w_py;
    logic [40:0]        w_zr;
    logic [56:0]        w_xr;
    logic [56:0]        w_yr;

    assign w_en    = !(r_out_vld && i_stall);
    assign o_stall = !w_en;
    assign w_acc   = i_valid && w_en;
    assign w_keep  = (i_range <= r_maxr) && ({3'b000, i_plane} < 8'(PLANES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vstep <= VSTEP_RST;
            r_maxr  <= MAXR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_VSTEP: r_vstep <= i_cfg_data[15:0];
                CFG_MAXR:  r_maxr  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // dropped returns enter as bubbles
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NV; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= w_acc && w_keep;
            for (int k = 1; k < NV; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_out_vld <= r_vld[NV-1];
        end
    end

    assign w_diff = $signed({3'b000, i_plane}) - $signed(8'(PLANE_OFFSET));
    assign n_d    = $signed({{17{w_diff[7]}}, w_diff}) * $signed({9'b0, r_vstep});
    assign w_dabs = r0_d[24] ? 25'(-r0_d) : 25'(r0_d);
    assign w_sm   = r0_step * YAW_RM;
    assign w_sq   = r0_step * YAW_Q;
    assign w_pa   = r1_m * M45;
    assign w_nq   = r2_n * YAW_Q;
    assign w_a45  = r2_a * 6'd45;
    assign w_b    = {1'b0, r2_m} - w_a45;
    assign w_pr   = r3_qe * YAW_N;
    assign w_rem  = {1'b0, r4_n} - r4_pr;
    assign w_p    = {r3_a[14:0], TAB45[r3_b]};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rng[0] <= i_range;
            for (int k = 1; k < NR; k++) begin
                r_rng[k] <= r_rng[k-1];
            end
            r0_step <= i_yaw_step;
            r0_d    <= n_d;
            r1_sm   <= w_sm;
            r1_sq   <= w_sq[31:0];
            r1_m    <= w_dabs[22:0];
            r1_neg  <= r0_d[24];
            r2_n    <= {1'b0, r1_sm} + {12'b0, YAW_H};
            r2_sq   <= r1_sq;
            r2_a    <= w_pa[46:29];
            r2_m    <= r1_m;
            r2_neg  <= r1_neg;
            r3_qe   <= w_nq[43:32];
            r3_n    <= r2_n;
            r3_sq   <= r2_sq;
            r3_a    <= r2_a;
            r3_b    <= w_b[5:0];
            r3_neg  <= r2_neg;
            r4_pr   <= w_pr;
            r4_qe   <= r3_qe;
            r4_n    <= r3_n;
            r4_sq   <= r3_sq;
            r4_p    <= w_p;
            r4_neg  <= r3_neg;
            // the estimate is at most one short
            r5_q2   <= (w_rem >= {12'b0, YAW_N}) ? r4_qe + 12'd1 : r4_qe;
            r5_sq   <= r4_sq;
            r5_pph  <= r4_neg ? 32'(-r4_p) : r4_p;
            r6_yph  <= r5_sq + {20'b0, r5_q2};
            r6_pph  <= r5_pph;
        end
    end

    lpc_sincos u_yaw (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_phase (r6_yph),
        .o_trig  (w_ty)
    );

    lpc_sincos u_pitch (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_phase (r6_pph),
        .o_trig  (w_tp)
    );

    assign w_cc = w_tp.c_mag * w_ty.c_mag;
    assign w_sc = w_tp.c_mag * w_ty.s_mag;
    assign w_zz = r_rng[NR-2] * w_tp.s_mag;
    assign w_px = r_rng[NR-1] * r_o1_cc;
    assign w_py = r_rng[NR-1] * r_o1_sc;
    assign w_zr = r_o1_zz + 41'h8000;
    assign w_xr = r_o2_px + 57'h8000_0000;
    assign w_yr = r_o2_py + 57'h8000_0000;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o1_cc <= w_cc[32:0];
            r_o1_sc <= w_sc[32:0];
            r_o1_zz <= w_zz;
            r_o1_xn <= w_tp.c_neg ^ w_ty.c_neg;
            r_o1_yn <= w_tp.c_neg ^ w_ty.s_neg;
            r_o1_zn <= w_tp.s_neg;
            r_o2_px <= w_px;
            r_o2_py <= w_py;
            r_o2_z  <= w_zr[39:16];
            r_o2_xn <= r_o1_xn;
            r_o2_yn <= r_o1_yn;
            r_o2_zn <= r_o1_zn;
            r_o3_x  <= w_xr[55:32];
            r_o3_y  <= w_yr[55:32];
            r_o3_z  <= r_o2_z;
            r_o3_xn <= r_o2_xn;
            r_o3_yn <= r_o2_yn;
            r_o3_zn <= r_o2_zn;
            r_pos_x <= r_o3_xn ? -$signed({1'b0, r_o3_x}) : $signed({1'b0, r_o3_x});
            r_pos_y <= r_o3_yn ? -$signed({1'b0, r_o3_y}) : $signed({1'b0, r_o3_y});
            r_pos_z <= r_o3_zn ? -$signed({1'b0, r_o3_z}) : $signed({1'b0, r_o3_z});
        end
    end

    assign o_valid = r_out_vld;
    assign o_pos_x = r_pos_x;
    assign o_pos_y = r_pos_y;
    assign o_pos_z = r_pos_z;

    // remaining trig fields and high product bits are not needed
    logic w_unused;
    assign w_unused = ^{w_ty.s_neg, w_cc[33], w_sc[33], w_sq[41:32], w_pa[28:0],
                        w_nq[58:44], w_nq[31:0], w_a45, w_b[23:6], w_zr[40],
                        w_zr[15:0], w_xr[56], w_xr[31:0], w_yr[56], w_yr[31:0],
                        r3_a[17:15], n_d[24]};

endmodule
`default_nettype wire

// ===== rtl/core/lpc_horner.sv =====
`default_nettype none
// one Horner step: v' = 1 - round(round(x2 * v) / D), four stages
module lpc_horner #(
    parameter int D = 72
) (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [29:0] i_x2,
    input  wire logic [30:0] i_v,
    output logic      [29:0] o_x2,
    output logic      [30:0] o_v
);
    import lpc_pkg::*;

    localparam int K = 31 + $clog2(D);
    localparam logic [31:0] M = 32'(((64'd1 << K) + 64'(D) - 64'd1) / 64'(D));
    localparam logic [30:0] HALF_D = 31'(D / 2);

    logic [29:0] r_x2 [4];
    logic [60:0] r_pr;
    logic [30:0] r_n;
    logic [62:0] r_pm;
    logic [30:0] r_v;

    logic [60:0] w_pr;
    logic [60:0] w_prr;
    logic [62:0] w_pm;
    logic [30:0] n_v;

    assign w_pr  = i_x2 * i_v;
    assign w_prr = r_pr + 61'h2000_0000;
    assign w_pm  = r_n * M;
    assign n_v   = ONE_Q30 - 31'(r_pm >> K);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x2[0] <= i_x2;
            for (int k = 1; k < 4; k++) begin
                r_x2[k] <= r_x2[k-1];
            end
            r_pr <= w_pr;
            r_n  <= w_prr[60:30] + HALF_D;
            r_pm <= w_pm;
            r_v  <= n_v;
        end
    end

    assign o_x2 = r_x2[3];
    assign o_v  = r_v;

endmodule
`default_nettype wire

// ===== rtl/core/lpc_sincos.sv =====
`default_nettype none
// sine and cosine of a 32-bit phase in Q16, sign and magnitude, SC_LAT stages
module lpc_sincos (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [31:0] i_phase,
    output lpc_pkg::t_trig   o_trig
);
    import lpc_pkg::*;

    localparam int SIN_D [4] = '{72, 42, 20, 6};
    localparam int COS_D [4] = '{56, 30, 12, 2};

    // fold
    logic [1:0]  r_quad;
    logic        r_swap;
    logic [29:0] r_rf;
    logic [61:0] r_p1;
    logic [29:0] r_rf1;
    logic [29:0] r_x;
    logic [59:0] r_xx;
    logic [29:0] r_x2;
    logic [29:0] r_xl [18];
    logic [2:0]  r_qsl [22];
    // tail
    logic [60:0] r_fp;
    logic [30:0] r_cv1;
    logic [30:0] r_s30;
    logic [30:0] r_cv2;
    t_trig       r_trig;

    logic [29:0] w_r;
    logic        w_swap;
    logic [30:0] w_flip;
    logic [61:0] w_p1;
    logic [61:0] w_xr;
    logic [59:0] w_xx;
    logic [59:0] w_x2r;
    logic [60:0] w_fp;
    logic [60:0] w_fpr;
    logic [30:0] w_sr;
    logic [30:0] w_cr;
    logic [16:0] w_s16;
    logic [16:0] w_c16;
    logic [16:0] w_s0;
    logic [16:0] w_c0;
    logic [1:0]  w_quad;
    t_trig       n_trig;

    logic [29:0] w_sx2 [5];
    logic [30:0] w_sv  [5];
    logic [29:0] w_cx2 [5];
    logic [30:0] w_cv  [5];

    assign w_r    = i_phase[29:0];
    assign w_swap = w_r > 30'h2000_0000;
    assign w_flip = 31'h4000_0000 - {1'b0, w_r};
    assign w_p1   = r_rf * HALF_PI_FRAC;
    assign w_xr   = r_p1 + 62'h8000_0000;
    assign w_xx   = r_x * r_x;
    assign w_x2r  = r_xx + 60'h2000_0000;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quad <= i_phase[31:30];
            r_swap <= w_swap;
            r_rf   <= w_swap ? w_flip[29:0] : w_r;
            r_p1   <= w_p1;
            r_rf1  <= r_rf;
            r_x    <= r_rf1 + w_xr[61:32];
            r_xx   <= w_xx;
            r_x2   <= w_x2r[59:30];
            r_xl[0]  <= r_x;
            r_qsl[0] <= {r_quad, r_swap};
            for (int k = 1; k < 18; k++) begin
                r_xl[k] <= r_xl[k-1];
            end
            for (int k = 1; k < 22; k++) begin
                r_qsl[k] <= r_qsl[k-1];
            end
        end
    end

    assign w_sx2[0] = r_x2;
    assign w_sv[0]  = ONE_Q30;
    assign w_cx2[0] = r_x2;
    assign w_cv[0]  = ONE_Q30;

    for (genvar g = 0; g < 4; g++) begin : g_round
        lpc_horner #(.D(SIN_D[g])) u_sin (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_x2  (w_sx2[g]),
            .i_v   (w_sv[g]),
            .o_x2  (w_sx2[g+1]),
            .o_v   (w_sv[g+1])
        );
        lpc_horner #(.D(COS_D[g])) u_cos (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_x2  (w_cx2[g]),
            .i_v   (w_cv[g]),
            .o_x2  (w_cx2[g+1]),
            .o_v   (w_cv[g+1])
        );
    end

    // sin = x * series, then both round to Q16
    assign w_fp  = r_xl[17] * w_sv[4];
    assign w_fpr = r_fp + 61'h2000_0000;
    assign w_sr  = r_s30 + 31'h2000;
    assign w_cr  = r_cv2 + 31'h2000;
    assign w_s16 = w_sr[30:14];
    assign w_c16 = w_cr[30:14];
    assign w_s0  = r_qsl[21][0] ? w_c16 : w_s16;
    assign w_c0  = r_qsl[21][0] ? w_s16 : w_c16;
    assign w_quad = r_qsl[21][2:1];

    always_comb begin
        n_trig = '0;
        unique case (w_quad)
            2'd0: begin
                n_trig = '{s_neg: 1'b0, s_mag: w_s0, c_neg: 1'b0, c_mag: w_c0};
            end
            2'd1: begin
                n_trig = '{s_neg: 1'b0, s_mag: w_c0, c_neg: 1'b1, c_mag: w_s0};
            end
            2'd2: begin
                n_trig = '{s_neg: 1'b1, s_mag: w_s0, c_neg: 1'b1, c_mag: w_c0};
            end
            default: begin
                n_trig = '{s_neg: 1'b1, s_mag: w_c0, c_neg: 1'b0, c_mag: w_s0};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fp   <= w_fp;
            r_cv1  <= w_cv[4];
            r_s30  <= w_fpr[60:30];
            r_cv2  <= r_cv1;
            r_trig <= n_trig;
        end
    end

    assign o_trig = r_trig;

    // x2 copies leave the last rounds unread
    logic w_unused;
    assign w_unused = ^{w_sx2[4], w_cx2[4]};

endmodule
`default_nettype wire

// ===== rtl/core/lpc_checker.sv =====
`default_nettype none
module lpc_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_stall,
    input wire logic               o_valid,
    input wire logic               i_stall,
    input wire logic signed [24:0] o_pos_x,
    input wire logic signed [24:0] o_pos_y,
    input wire logic signed [24:0] o_pos_z
);

    // reset empties the output
    a_rst_clear: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a stalled result is held
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pos_x) && $stable(o_pos_y)
                               && $stable(o_pos_z))
        else $error("stalled result changed");

    // input is held back only behind a stalled result
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a stalled result");

    // magnitudes never exceed the range, so the most negative code cannot occur
    a_mag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_pos_x != 25'h1000000 && o_pos_y != 25'h1000000
                    && o_pos_z != 25'h1000000)
        else $error("coordinate out of range");

endmodule

bind lidar_polar_to_cartesian lpc_checker u_lpc_checker (.*);
`default_nettype wire
